### rtl/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int OCC_W         = 5;

    localparam logic signed [DATA_W-1:0] DATA_UNDERFLOW = '1;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_READ = 1'b1
    } fsm_t;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [DATA_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } out_word_t;

endpackage

### rtl/double_ended_queue_unit.sv
// channel   ports                          payload
// input     s_valid, s_ready, s_word       opcode, value
// result    m_valid, m_ready, m_word       data, status, occupancy
//
// every word passes through the idle and read states: the slot ram is read or
// written on the accept edge and its registered read data is loaded into the
// result register in the read state; no new word is taken during the read state
// synchronous active-low reset empties the queue; slot contents are not cleared
// the next word is taken while the previous result is still being drained
// a stalled result register holds off the input until m_ready frees it
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                     mem_we;
    logic                     mem_re;
    logic [AW-1:0]            mem_addr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic signed [DATA_W-1:0] mem_rdata;
    logic [CW-1:0]            fill;

    deq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .fill      (fill)
    );

    deq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while one is in flight");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result register busy when a new result is due");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_under_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status == ST_UNDER |-> m_word.data == DATA_UNDERFLOW)
        else $error("underflow result without all-ones data");

    a_no_access_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("slot ram read and written in one cycle");

endmodule

### rtl/deq_mem.sv
module deq_mem
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [AW-1:0]            addr,
    input  logic signed [DATA_W-1:0] wdata,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/deq_ctrl.sv
module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_word_t                 s_word,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_word_t                m_word,
    output logic                     mem_we,
    output logic                     mem_re,
    output logic [AW-1:0]            mem_addr,
    output logic signed [DATA_W-1:0] mem_wdata,
    input  logic signed [DATA_W-1:0] mem_rdata,
    output logic [CW-1:0]            fill
);

    fsm_t            state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            m_valid_reg, m_valid_next;
    out_word_t       m_word_reg, m_word_next;
    logic            pend_rd_reg, pend_rd_next;
    status_t         pend_status_reg, pend_status_next;
    logic [OCC_W-1:0] pend_occ_reg, pend_occ_next;
    logic            accept;
    logic            full;
    logic            empty;
    logic [CW-1:0]   count_m1;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - 1'b1;
    assign s_ready  = (state_reg == FSM_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg      <= m_word_next;
        pend_rd_reg     <= pend_rd_next;
        pend_status_reg <= pend_status_next;
        pend_occ_reg    <= pend_occ_next;
    end

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_word_next      = m_word_reg;
        pend_rd_next     = pend_rd_reg;
        pend_status_next = pend_status_reg;
        pend_occ_next    = pend_occ_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_addr         = head_reg;
        mem_wdata        = s_word.value;

        unique case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    pend_rd_next     = 1'b0;
                    pend_status_next = ST_OK;
                    unique case (s_word.opcode)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (full) begin
                                pend_status_next = ST_OVER;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (s_word.opcode == OP_PUSH_FRONT) begin
                                    head_next = (head_reg == '0) ? AW'(DEPTH - 1)
                                                                 : head_reg - 1'b1;
                                    mem_addr  = head_next;
                                end else begin
                                    mem_addr = ring_add(head_reg, AW'(count_reg));
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                            if (empty) begin
                                pend_status_next = ST_UNDER;
                            end else begin
                                mem_re       = 1'b1;
                                pend_rd_next = 1'b1;
                                if (s_word.opcode == OP_POP_FRONT ||
                                    s_word.opcode == OP_PEEK_FRONT) begin
                                    mem_addr = head_reg;
                                end else begin
                                    mem_addr = ring_add(head_reg, AW'(count_m1));
                                end
                                if (s_word.opcode == OP_POP_FRONT) begin
                                    head_next  = ring_add(head_reg, AW'(1));
                                    count_next = count_m1;
                                end else if (s_word.opcode == OP_POP_BACK) begin
                                    count_next = count_m1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    pend_occ_next = OCC_W'(count_next);
                    state_next    = FSM_READ;
                end
            end
            FSM_READ: begin
                m_valid_next     = 1'b1;
                m_word_next.status    = pend_status_reg;
                m_word_next.occupancy = pend_occ_reg;
                if (pend_rd_reg) begin
                    m_word_next.data = mem_rdata;
                end else if (pend_status_reg == ST_UNDER) begin
                    m_word_next.data = DATA_UNDERFLOW;
                end else begin
                    m_word_next.data = '0;
                end
                state_next = FSM_IDLE;
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;
    assign fill    = count_reg;

endmodule

### bench/tb_double_ended_queue_unit.sv
`timescale 1ns / 100ps

module tb_double_ended_queue_unit
    import deq_pkg::*;
();

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int RANDOM_WORDS = 1500;
    localparam int IDLE_LIMIT = 400;
    localparam int TAIL_CYCLES = 20;
    localparam int SHOW_MAX = 10;

    // opcodes with no meaning, the unit must ignore them
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;
    typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_t;

    typedef struct {
        in_word_t word;
        int       gap;
        bit       hold_for_drain;
    } pending_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    pending_t  word_backlog[$];
    out_word_t due_results[$];

    // deque shadow
    logic signed [DATA_W-1:0] slot_mem [DEPTH];
    int head_pos = 0;
    int fill_cnt = 0;

    int sent_cnt = 0;
    int got_cnt = 0;
    int bad_cnt = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    bit gap_armed = 1'b0;
    int stall_left = 0;
    bit rx_calm = 1'b0;

    int n_push = 0;
    int n_take = 0;
    int n_under = 0;
    int n_over = 0;
    int n_full = 0;
    int n_ignored = 0;

    double_ended_queue_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always #4 aclk = ~aclk;

    function automatic out_word_t deque_apply(in_word_t w);
        out_word_t r;
        int pos;
        r.data = '0;
        r.status = ST_OK;
        case (w.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (fill_cnt == DEPTH) begin
                    r.status = ST_OVER;
                    n_over++;
                end else begin
                    if (w.opcode == OP_PUSH_FRONT) begin
                        head_pos = (head_pos + DEPTH - 1) % DEPTH;
                        pos = head_pos;
                    end else begin
                        pos = (head_pos + fill_cnt) % DEPTH;
                    end
                    slot_mem[pos] = w.value;
                    fill_cnt++;
                    n_push++;
                    if (fill_cnt == DEPTH) n_full++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                if (fill_cnt == 0) begin
                    r.status = ST_UNDER;
                    r.data = DATA_UNDERFLOW;
                    n_under++;
                end else begin
                    if (w.opcode == OP_POP_FRONT || w.opcode == OP_PEEK_FRONT)
                        pos = head_pos;
                    else
                        pos = (head_pos + fill_cnt - 1) % DEPTH;
                    r.data = slot_mem[pos];
                    n_take++;
                    if (w.opcode == OP_POP_FRONT) begin
                        head_pos = (head_pos + 1) % DEPTH;
                        fill_cnt--;
                    end else if (w.opcode == OP_POP_BACK) begin
                        fill_cnt--;
                    end
                end
            end
            default: begin
                n_ignored++;
            end
        endcase
        r.occupancy = OCC_W'(fill_cnt);
        return r;
    endfunction

    task automatic queue_word(logic [2:0] op, logic signed [DATA_W-1:0] v, int gap,
                              bit hold);
        pending_t p;
        p.word.opcode = op;
        p.word.value = v;
        p.gap = gap;
        p.hold_for_drain = hold;
        word_backlog = {word_backlog, p};
    endtask

    function automatic logic [2:0] pick_op(mix_t mix);
        int r;
        int push_pct;
        r = $urandom_range(0, 99);
        push_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 22 : 46;
        if (r < 4)
            return (r < 2) ? OP_SPARE_LO : OP_SPARE_HI;
        if (r < 4 + push_pct)
            return ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        if (r < 88)
            return ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;
        return ($urandom_range(0, 1) != 0) ? OP_PEEK_FRONT : OP_PEEK_BACK;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_gap(pace_t pace);
        case (pace)
            PACE_FULL: return 0;
            PACE_LIGHT: return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 11) : 0;
            default: return $urandom_range(0, 11);
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        logic      nxt_valid;
        in_word_t  nxt_word;
        bit        took;
        out_word_t exp_word;
        nxt_valid = s_valid;
        nxt_word = s_word;
        took = 1'b0;
        if (!aresetn) begin
            nxt_valid = 1'b0;
            gap_armed = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                exp_word = deque_apply(s_word);
                due_results = {due_results, exp_word};
                sent_cnt <= sent_cnt + 1;
                took = 1'b1;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && word_backlog.size() > 0) begin
                if (!gap_armed) begin
                    gap_left = word_backlog[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!word_backlog[0].hold_for_drain
                             || sent_cnt + int'(took) == got_cnt) begin
                    nxt_word = word_backlog[0].word;
                    word_backlog.delete(0);
                    nxt_valid = 1'b1;
                    gap_armed = 1'b0;
                end
            end
        end
        s_valid <= nxt_valid;
        s_word <= nxt_word;
    end

    // monitor
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                got_cnt <= got_cnt + 1;
                if (due_results.size() == 0) begin
                    bad_cnt++;
                    if (bad_cnt <= SHOW_MAX)
                        $display("unexpected result word: data %0d status %0d occupancy %0d",
                                 m_word.data, m_word.status, m_word.occupancy);
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    if (m_word.data !== want.data || m_word.status !== want.status
                        || m_word.occupancy !== want.occupancy) begin
                        bad_cnt++;
                        if (bad_cnt <= SHOW_MAX)
                            $display("mismatch at result %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     got_cnt, want.data, want.status, want.occupancy,
                                     m_word.data, m_word.status, m_word.occupancy);
                    end
                end
                if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
                stall_left = rx_calm ? 0 : $urandom_range(0, 11);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("double_ended_queue_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int    seg_len;
        int    seg_idx;
        int    made;
        mix_t  mix;
        pace_t pace;

        // empty queue, then ignored opcodes, then two pushes read back from both ends
        queue_word(OP_POP_FRONT, VAL_MAX, 0, 1'b0);
        queue_word(OP_POP_BACK, '0, 3, 1'b0);
        queue_word(OP_PEEK_FRONT, '1, 0, 1'b0);
        queue_word(OP_PEEK_BACK, VAL_MIN, 11, 1'b0);
        queue_word(OP_SPARE_LO, '1, 0, 1'b0);
        queue_word(OP_SPARE_HI, VAL_MAX, 0, 1'b0);
        queue_word(OP_PUSH_FRONT, VAL_MAX, 0, 1'b0);
        queue_word(OP_PUSH_BACK, VAL_MIN, 0, 1'b0);
        queue_word(OP_PEEK_FRONT, '0, 0, 1'b0);
        queue_word(OP_PEEK_BACK, '0, 5, 1'b0);
        queue_word(OP_POP_BACK, '0, 0, 1'b0);
        queue_word(OP_POP_FRONT, '0, 0, 1'b0);
        // fill to the top and push past it at both ends
        for (int i = 0; i < DEPTH; i++)
            queue_word((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value(),
                       $urandom_range(0, 2), 1'b0);
        queue_word(OP_PUSH_FRONT, '1, 0, 1'b0);
        queue_word(OP_PUSH_BACK, VAL_MAX, 0, 1'b0);

        made = 0;
        seg_idx = 0;
        while (made < RANDOM_WORDS) begin
            seg_len = $urandom_range(20, 80);
            mix = mix_t'($urandom_range(0, 2));
            pace = pace_t'($urandom_range(0, 2));
            for (int i = 0; i < seg_len; i++) begin
                queue_word(pick_op(mix), pick_value(), pick_gap(pace),
                           i == 0 && seg_idx % 6 == 0);
                made++;
            end
            seg_idx++;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (word_backlog.size() > 0 || s_valid || sent_cnt != got_cnt);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (due_results.size() > 0) begin
            bad_cnt += due_results.size();
            $display("%0d results never arrived", due_results.size());
        end
        $display("%0d words, %0d mismatches: %0d pushes, %0d pops/peeks, %0d ignored",
                 sent_cnt, bad_cnt, n_push, n_take, n_ignored);
        $display("%0d underflows, %0d overflows, queue reached full %0d times",
                 n_under, n_over, n_full);
        if (bad_cnt == 0)
            $display("double_ended_queue_unit regression: pass");
        else
            $display("double_ended_queue_unit regression: fail");
        $finish;
    end

endmodule
